[hdl/kac_pkg.sv]
// ----------------------------------------------------------------------------
// kac_pkg
// Shared types and constants for the keypad alarm controller: register
// indexes, item kinds, field widths and reset values.
// ----------------------------------------------------------------------------
package kac_pkg;

    // Default build parameters.
    localparam int CODE_DIGITS_DEF = 4;
    localparam int ZONES_DEF       = 8;

    // Fixed field widths.
    localparam int DIGIT_W    = 4;
    localparam int PW_W       = 16;
    localparam int PW_DIGITS  = PW_W / DIGIT_W;
    localparam int TICKS_W    = 16;
    localparam int PERIOD_W   = 8;
    localparam int ATT_W      = 2;
    localparam int SHOWN_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values of the registers and counters.
    localparam logic [PW_W-1:0]     PASSWORD_RST = '0;
    localparam logic [TICKS_W-1:0]  TICKS_RST    = 16'd1000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd100;
    localparam logic [ATT_W-1:0]    ATT_LOCKOUT  = 2'd3;
    localparam logic [ATT_W-1:0]    ATT_LAST_TRY = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PASSWORD       = 2'd0,
        REG_ARM_DELAY      = 2'd1,
        REG_ENTRY_TIMEOUT  = 2'd2,
        REG_SENSOR_PERIOD  = 2'd3
    } cfg_reg_t;

    // Kind of an input item.
    typedef enum logic {
        ITEM_TICK = 1'b0,
        ITEM_KEY  = 1'b1
    } item_kind_t;

endpackage

[hdl/kac_fifo.sv]
// ----------------------------------------------------------------------------
// kac_fifo
// Small register queue with push/full and pop/empty sides. Decouples the
// item intake from the state engine and the engine from the result reader.
// ----------------------------------------------------------------------------
module kac_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hdl/kac_engine.sv]
// ----------------------------------------------------------------------------
// kac_engine
// Alarm state engine. Holds the configuration registers and the alarm
// state, applies one tick or key item per cycle while the result queue
// has room and hands the updated status to the result queue.
// ----------------------------------------------------------------------------
module kac_engine #(
    parameter int CODE_DIGITS = kac_pkg::CODE_DIGITS_DEF,
    parameter int ZONES       = kac_pkg::ZONES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration writes.
    input  logic                            cfg_write,
    input  logic [kac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kac_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Item side.
    input  logic                            item_valid,
    input  kac_pkg::item_kind_t             item_kind,
    input  logic [kac_pkg::DIGIT_W-1:0]     item_digit,
    input  logic [ZONES-1:0]                item_lines,
    output logic                            item_pop,
    // Result side.
    input  logic                            res_full,
    output logic                            res_push,
    output logic                            res_armed,
    output logic                            res_arming,
    output logic                            res_siren,
    output logic [kac_pkg::ATT_W-1:0]       res_attempts,
    output logic [kac_pkg::SHOWN_W-1:0]     res_digits,
    output logic [ZONES-1:0]                res_zones
);

    import kac_pkg::*;

    localparam int LEN_W = $clog2(CODE_DIGITS + 1);

    // Configuration registers.
    logic [PW_W-1:0]     pw_reg;
    logic [TICKS_W-1:0]  arm_delay_reg;
    logic [TICKS_W-1:0]  timeout_reg;
    logic [PERIOD_W-1:0] period_reg;

    // Alarm state.
    logic                armed_reg, armed_next;
    logic                timer_on_reg, timer_on_next;
    logic                siren_reg, siren_next;
    logic [TICKS_W-1:0]  arm_cnt_reg, arm_cnt_next;
    logic [TICKS_W-1:0]  aec_reg, aec_next;
    logic [TICKS_W-1:0]  iec_reg, iec_next;
    logic                armed_pend_reg, armed_pend_next;
    logic                idle_pend_reg, idle_pend_next;
    logic [PERIOD_W-1:0] sens_cnt_reg, sens_cnt_next;
    logic                sample_pend_reg, sample_pend_next;
    logic [ATT_W-1:0]    att_reg, att_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [ZONES-1:0]    zone_reg, zone_next;
    logic [DIGIT_W-1:0]  digit_reg [CODE_DIGITS];

    logic                    take;
    logic [CODE_DIGITS-1:0]  lane_ok;
    logic                    code_match;

    assign take     = item_valid && !res_full;
    assign item_pop = take;
    assign res_push = take;

    // Configuration write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg        <= PASSWORD_RST;
            arm_delay_reg <= TICKS_RST;
            timeout_reg   <= TICKS_RST;
            period_reg    <= PERIOD_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PASSWORD:      pw_reg        <= cfg_data[PW_W-1:0];
                REG_ARM_DELAY:     arm_delay_reg <= cfg_data[TICKS_W-1:0];
                REG_ENTRY_TIMEOUT: timeout_reg   <= cfg_data[TICKS_W-1:0];
                REG_SENSOR_PERIOD: period_reg    <= cfg_data[PERIOD_W-1:0];
                default:           pw_reg        <= pw_reg;
            endcase
        end
    end

    // Digit lanes: each lane stores the key pressed at its position and
    // compares it with its password digit. The lane at the current position
    // sees the incoming key, which completes the entry on the last digit.
    for (genvar i = 0; i < CODE_DIGITS; i++)
    begin : g_lane
        logic [DIGIT_W-1:0] code_digit;
        logic [DIGIT_W-1:0] entry_digit;

        if (i < PW_DIGITS)
        begin : g_stored
            assign code_digit = pw_reg[i*DIGIT_W +: DIGIT_W];
        end
        else
        begin : g_zero
            assign code_digit = '0;
        end

        assign entry_digit = (len_reg == LEN_W'(i)) ? item_digit : digit_reg[i];
        assign lane_ok[i]  = (entry_digit == code_digit);

        always_ff @(posedge clk)
        begin
            if (take && item_kind == ITEM_KEY && len_reg == LEN_W'(i))
            begin
                digit_reg[i] <= item_digit;
            end
        end
    end

    assign code_match = &lane_ok;

    // Item update: a key extends the entry and may complete it, a tick
    // runs the countdowns, the timeouts and the sensor sample.
    always_comb
    begin
        armed_next       = armed_reg;
        timer_on_next    = timer_on_reg;
        siren_next       = siren_reg;
        arm_cnt_next     = arm_cnt_reg;
        aec_next         = aec_reg;
        iec_next         = iec_reg;
        armed_pend_next  = armed_pend_reg;
        idle_pend_next   = idle_pend_reg;
        sens_cnt_next    = sens_cnt_reg;
        sample_pend_next = sample_pend_reg;
        att_next         = att_reg;
        len_next         = len_reg;
        zone_next        = zone_reg;

        if (item_kind == ITEM_KEY)
        begin
            len_next        = len_reg + 1'b1;
            aec_next        = timeout_reg;
            armed_pend_next = 1'b0;
            iec_next        = timeout_reg;
            idle_pend_next  = 1'b0;
            if (len_next == LEN_W'(CODE_DIGITS))
            begin
                len_next = '0;
                if (!code_match)
                begin
                    if (att_reg < ATT_LAST_TRY)
                    begin
                        att_next = att_reg + 1'b1;
                    end
                    else if (att_reg == ATT_LAST_TRY)
                    begin
                        siren_next = 1'b1;
                        att_next   = ATT_LOCKOUT;
                    end
                end
                else if (!armed_reg && !siren_reg)
                begin
                    arm_cnt_next  = arm_delay_reg;
                    timer_on_next = 1'b1;
                    att_next      = '0;
                end
                else
                begin
                    armed_next    = 1'b0;
                    timer_on_next = 1'b0;
                    arm_cnt_next  = arm_delay_reg;
                    att_next      = '0;
                    siren_next    = 1'b0;
                    zone_next     = '0;
                end
            end
        end
        else
        begin
            // Idle entry timer always runs.
            iec_next = iec_reg - 1'b1;
            if (iec_next == '0)
            begin
                iec_next       = timeout_reg;
                idle_pend_next = 1'b1;
            end

            // Countdowns that run while arming or armed.
            if (timer_on_reg)
            begin
                aec_next      = aec_reg - 1'b1;
                arm_cnt_next  = arm_cnt_reg - 1'b1;
                sens_cnt_next = sens_cnt_reg - 1'b1;
                if (aec_next == '0)
                begin
                    aec_next        = timeout_reg;
                    armed_pend_next = 1'b1;
                end
                if (arm_cnt_next == '0)
                begin
                    arm_cnt_next = arm_delay_reg;
                    armed_next   = 1'b1;
                end
                if (sens_cnt_next == '0)
                begin
                    sens_cnt_next    = period_reg;
                    sample_pend_next = 1'b1;
                end
            end

            // Armed timeout drops a partial entry and counts an attempt.
            if (armed_pend_next && len_reg != '0 && armed_next)
            begin
                len_next = '0;
                if (att_reg < ATT_LOCKOUT)
                begin
                    att_next = att_reg + 1'b1;
                end
                aec_next        = timeout_reg;
                armed_pend_next = 1'b0;
            end

            // Idle timeout drops a partial entry while not armed.
            if (idle_pend_next && len_next != '0 && !armed_next)
            begin
                len_next       = '0;
                iec_next       = timeout_reg;
                idle_pend_next = 1'b0;
            end

            // Sensor sample while armed.
            if (armed_next && sample_pend_next)
            begin
                zone_next        = item_lines;
                sample_pend_next = 1'b0;
                if (item_lines != '0)
                begin
                    siren_next = 1'b1;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            timer_on_reg    <= 1'b0;
            siren_reg       <= 1'b0;
            arm_cnt_reg     <= TICKS_RST;
            aec_reg         <= TICKS_RST;
            iec_reg         <= TICKS_RST;
            armed_pend_reg  <= 1'b0;
            idle_pend_reg   <= 1'b0;
            sens_cnt_reg    <= PERIOD_RST;
            sample_pend_reg <= 1'b0;
            att_reg         <= '0;
            len_reg         <= '0;
            zone_reg        <= '0;
        end
        else if (take)
        begin
            armed_reg       <= armed_next;
            timer_on_reg    <= timer_on_next;
            siren_reg       <= siren_next;
            arm_cnt_reg     <= arm_cnt_next;
            aec_reg         <= aec_next;
            iec_reg         <= iec_next;
            armed_pend_reg  <= armed_pend_next;
            idle_pend_reg   <= idle_pend_next;
            sens_cnt_reg    <= sens_cnt_next;
            sample_pend_reg <= sample_pend_next;
            att_reg         <= att_next;
            len_reg         <= len_next;
            zone_reg        <= zone_next;
        end
    end

    // Status after the update goes to the result queue.
    assign res_armed    = armed_next;
    assign res_arming   = timer_on_next;
    assign res_siren    = siren_next;
    assign res_attempts = att_next;
    assign res_digits   = SHOWN_W'(len_next);
    assign res_zones    = zone_next;

endmodule

[hdl/keypad_alarm_controller.sv]
// ----------------------------------------------------------------------------
// keypad_alarm_controller
// Intruder alarm controller driven by ticks and keypad digits.
// ----------------------------------------------------------------------------
// Usage:
// Items enter through a queue-style port: drive mode, key_digit and
// sensor_lines and raise push; the beat is taken at a clock edge where
// full is low. A tick (mode 0) carries the sensor lines, a key (mode 1)
// carries one digit. Every item yields one status beat, read queue-style:
// while empty is low the oldest status is on the result ports, and pop
// takes it. Registers are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce it.
// An accepted item passes from the intake queue to the state engine, and
// its status beat is registered into the status queue. The engine applies
// one item per cycle while the status queue has room, so one item per
// cycle is sustained while the reader pops. Two-entry queues on each side
// let intake run on while a beat waits; full rises only once both are full.
// Reset clears the alarm, empties both queues and reloads the register
// defaults (password 0, 1000-tick delays, 100-tick period).
// ----------------------------------------------------------------------------
module keypad_alarm_controller #(
    parameter int CODE_DIGITS = kac_pkg::CODE_DIGITS_DEF,
    parameter int ZONES       = kac_pkg::ZONES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration.
    input  logic                            cfg_write,
    input  logic [kac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kac_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Items.
    input  logic                            push,
    output logic                            full,
    input  logic                            mode,
    input  logic [kac_pkg::DIGIT_W-1:0]     key_digit,
    input  logic [ZONES-1:0]                sensor_lines,
    // Status.
    output logic                            empty,
    input  logic                            pop,
    output logic                            armed,
    output logic                            arming,
    output logic                            siren_on,
    output logic [kac_pkg::ATT_W-1:0]       failed_attempts,
    output logic [kac_pkg::SHOWN_W-1:0]     digits_entered,
    output logic [ZONES-1:0]                violated_zones
);

    import kac_pkg::*;

    localparam int ITEM_W = 1 + DIGIT_W + ZONES;
    localparam int RES_W  = 3 + ATT_W + SHOWN_W + ZONES;

    logic [ITEM_W-1:0]  item_wdata, item_rdata;
    logic               item_empty;
    logic               item_pop;
    item_kind_t         item_kind;
    logic [DIGIT_W-1:0] item_digit;
    logic [ZONES-1:0]   item_lines;

    logic               res_full;
    logic               res_push;
    logic               res_armed;
    logic               res_arming;
    logic               res_siren;
    logic [ATT_W-1:0]   res_attempts;
    logic [SHOWN_W-1:0] res_digits;
    logic [ZONES-1:0]   res_zones;
    logic [RES_W-1:0]   res_wdata, res_rdata;

    // Front: intake queue; items are split by kind on the way out.
    assign item_wdata = {mode, key_digit, sensor_lines};

    kac_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_wdata),
        .full  (full),
        .pop   (item_pop),
        .rdata (item_rdata),
        .empty (item_empty)
    );

    assign item_kind  = item_kind_t'(item_rdata[ITEM_W-1]);
    assign item_digit = item_rdata[ZONES +: DIGIT_W];
    assign item_lines = item_rdata[ZONES-1:0];

    // Back: state engine.
    kac_engine #(
        .CODE_DIGITS (CODE_DIGITS),
        .ZONES       (ZONES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (!item_empty),
        .item_kind    (item_kind),
        .item_digit   (item_digit),
        .item_lines   (item_lines),
        .item_pop     (item_pop),
        .res_full     (res_full),
        .res_push     (res_push),
        .res_armed    (res_armed),
        .res_arming   (res_arming),
        .res_siren    (res_siren),
        .res_attempts (res_attempts),
        .res_digits   (res_digits),
        .res_zones    (res_zones)
    );

    // Status queue toward the reader.
    assign res_wdata = {res_armed, res_arming, res_siren, res_attempts, res_digits, res_zones};

    kac_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign armed           = res_rdata[RES_W-1];
    assign arming          = res_rdata[RES_W-2];
    assign siren_on        = res_rdata[RES_W-3];
    assign failed_attempts = res_rdata[ZONES + SHOWN_W +: ATT_W];
    assign digits_entered  = res_rdata[ZONES +: SHOWN_W];
    assign violated_zones  = res_rdata[ZONES-1:0];

endmodule

[hdl/kac_checker.sv]
// ----------------------------------------------------------------------------
// kac_checker
// Port-level checks of the alarm controller's status beats, bound to the
// top level.
// ----------------------------------------------------------------------------
module kac_checker #(
    parameter int ZONES = kac_pkg::ZONES_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            empty,
    input logic                            pop,
    input logic                            armed,
    input logic                            arming,
    input logic                            siren_on,
    input logic [kac_pkg::ATT_W-1:0]       failed_attempts,
    input logic [kac_pkg::SHOWN_W-1:0]     digits_entered,
    input logic [ZONES-1:0]                violated_zones
);

    logic [kac_pkg::ATT_W + kac_pkg::SHOWN_W + ZONES + 2:0] status;

    assign status = {armed, arming, siren_on, failed_attempts, digits_entered, violated_zones};

    // An armed alarm always has its countdown timer running.
    a_armed_timer: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && armed |-> arming)
        else $error("armed shown without the arming timer");

    // Zone bits are only sampled while armed and are cleared on disarm.
    a_zones_armed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && violated_zones != '0 |-> armed)
        else $error("violated zones shown while not armed");

    // A violated zone sounds the siren until the next disarm.
    a_zones_siren: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && violated_zones != '0 |-> siren_on)
        else $error("violated zones shown with the siren off");

    // A waiting status beat holds until it is popped.
    a_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status))
        else $error("status beat changed or vanished while stalled");

endmodule

bind keypad_alarm_controller kac_checker #(.ZONES(ZONES)) u_kac_checker (.*);
